// ===== rtl/keyframe_linear_interpolator_assert.svh =====
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH

// same-cycle implication under synchronous reset
`define KLI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kli assertion failed");

// next-cycle implication under synchronous reset
`define KLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kli assertion failed");

`endif

// ===== rtl/kli_pkg.sv =====
`default_nettype none
package kli_pkg;

    localparam int TIME_W      = 32;
    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int MAX_POINTS_DEF = 16;
    localparam int STEP_W      = 6;

    localparam logic [1:0] REG_START_TIME = 2'd0;
    localparam logic [1:0] REG_PATH_MODE  = 2'd1;
    localparam logic [1:0] REG_POINT_CNT  = 2'd2;
    localparam logic [1:0] REG_USE_WEIGHT = 2'd3;

    localparam logic [1:0] MODE_ONCE     = 2'd0;
    localparam logic [1:0] MODE_LOOP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic [3:0]                 point_index;
        logic [TIME_W-1:0]          segment_ticks;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  point_z;
        logic signed [COORD_W-1:0]  point_w;
        logic [TIME_W-1:0]          query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic [4:0]         segment;
        logic [16:0]        fraction;
        logic               invalid;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0]         ticks;
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic done;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_USE,
        ST_P0_RD,
        ST_P0_USE,
        ST_DIV,
        ST_WALK_RD,
        ST_WALK_USE,
        ST_NEXT_RD,
        ST_NEXT_USE,
        ST_FRAC,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    function automatic logic [TIME_W-1:0] seg_ticks(input t_entry e, input logic use_w);
        logic [TIME_W-1:0] d;
        if (use_w) begin
            d = e.w[COORD_W-1] ? '0 : TIME_W'(e.w[COORD_W-1:16]);
        end else begin
            d = e.ticks;
        end
        return d;
    endfunction

    function automatic logic signed [COORD_W-1:0] coord_of(input t_entry e,
                                                          input logic [1:0] j);
        logic signed [COORD_W-1:0] c;
        case (j)
            2'd0:    c = e.x;
            2'd1:    c = e.y;
            2'd2:    c = e.z;
            default: c = e.w;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/keyframe_linear_interpolator.sv =====
// channel   | direction | handshake               | payload
// in        | input     | i_in_valid / o_in_stall | i_in_data (t_in_item)
// out       | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
// cfg       | input     | psel/penable/pwrite     | paddr, pwdata, prdata
// a load is written in the idle state; a query sums the segment durations, takes
// the modulo in loop or ping-pong mode, walks the segments, divides for the
// fraction and then blends the four coordinates; the reads go through the
// single-port point memory and both divides through the bit-serial divider
// synchronous active-low reset; no clearing pass, the point memory is not cleared
// a stalled result sits in the output register; the next query waits only at its end
`default_nettype none
module keyframe_linear_interpolator #(
    parameter int MAX_POINTS = kli_pkg::MAX_POINTS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  kli_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output kli_pkg::t_out_item  o_out_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import kli_pkg::*;

    localparam int IW      = $clog2(MAX_POINTS);
    localparam int CW      = $clog2(MAX_POINTS + 1);
    localparam int TOTAL_W = TIME_W + IW;
    localparam int NUM_W   = TIME_W + FRAC_W;

    logic [31:0] r_start_time;
    logic [1:0]  r_path_mode;
    logic [4:0]  r_point_count;
    logic        r_use_w;

    t_state r_state, n_state;

    t_entry r_mem [MAX_POINTS];
    t_entry r_rd_data;
    logic [IW-1:0] rd_addr;

    logic [CW-1:0]      r_n, r_nseg, r_i;
    logic               r_before;
    logic [TOTAL_W-1:0] r_total, r_tm, r_walk;
    t_entry             r_prev, r_cur;
    logic [TIME_W-1:0]  r_dprev;
    logic [16:0]        r_frac;
    logic [4:0]         r_seg;
    logic               r_inv;
    logic [1:0]         r_j;
    logic signed [50:0] r_prod;
    logic signed [31:0] r_res  [4];
    logic signed [31:0] r_held [4];
    t_out_item          r_out;
    logic               r_out_valid;

    logic               in_acc, out_free, cfg_wr;
    logic [TIME_W-1:0]  d_rd;
    logic [TOTAL_W-1:0] rem_frac, tm_mod;
    logic               frac_full;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic [TOTAL_W-1:0] div_rem_init, div_rem;
    logic [NUM_W-1:0]   div_num_init;
    logic [31:0]        div_quo;
    logic [31:0]        n32;
    logic signed [32:0] diff;
    logic signed [17:0] frac_s;
    logic signed [31:0] coord_a;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time  <= '0;
            r_path_mode   <= MODE_ONCE;
            r_point_count <= 5'd5;
            r_use_w       <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_START_TIME: r_start_time  <= pwdata;
                REG_PATH_MODE:  r_path_mode   <= pwdata[1:0];
                REG_POINT_CNT:  r_point_count <= pwdata[4:0];
                REG_USE_WEIGHT: r_use_w       <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START_TIME: prdata = r_start_time;
            REG_PATH_MODE:  prdata = {30'd0, r_path_mode};
            REG_POINT_CNT:  prdata = {27'd0, r_point_count};
            REG_USE_WEIGHT: prdata = {31'd0, r_use_w};
        endcase
    end

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign d_rd     = seg_ticks(r_rd_data, r_use_w);
    assign rem_frac = r_tm - (r_walk - TOTAL_W'(r_dprev));
    assign frac_full = rem_frac >= TOTAL_W'(r_dprev);
    assign tm_mod   = ((r_path_mode == MODE_PINGPONG) && div_quo[0]) ?
                      (r_total - div_rem) : div_rem;
    assign n32      = (32'(r_point_count) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS)
                                                              : 32'(r_point_count);
    assign coord_a  = coord_of(r_prev, r_j);
    assign diff     = 33'(coord_of(r_cur, r_j)) - 33'(coord_a);
    assign frac_s   = $signed({1'b0, r_frac});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.kind == KIND_QUERY)) n_state = ST_SUM_RD;
            end
            ST_SUM_RD: begin
                if (r_n == '0)              n_state = ST_DONE;
                else if (r_i < r_nseg)      n_state = ST_SUM_USE;
                else if (r_before || (r_nseg == '0)) n_state = ST_P0_RD;
                else if ((r_path_mode == MODE_LOOP) || (r_path_mode == MODE_PINGPONG))
                    n_state = ST_DIV;
                else                        n_state = ST_WALK_RD;
            end
            ST_SUM_USE:  n_state = (d_rd == '0) ? ST_DONE : ST_SUM_RD;
            ST_P0_RD:    n_state = ST_P0_USE;
            ST_P0_USE:   n_state = ST_DONE;
            ST_DIV:      if (div_rsp.done) n_state = ST_WALK_RD;
            ST_WALK_RD:  n_state = ((r_i < r_nseg) && (r_tm >= r_walk)) ? ST_WALK_USE
                                                                      : ST_NEXT_RD;
            ST_WALK_USE: n_state = ST_WALK_RD;
            ST_NEXT_RD:  n_state = ST_NEXT_USE;
            ST_NEXT_USE: begin
                if (r_tm > r_walk)  n_state = ST_DONE;
                else if (frac_full) n_state = ST_MUL;
                else                n_state = ST_FRAC;
            end
            ST_FRAC:     if (div_rsp.done) n_state = ST_MUL;
            ST_MUL:      n_state = ST_ADD;
            ST_ADD:      n_state = (r_j == 2'd3) ? ST_DONE : ST_MUL;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall    = (r_state != ST_IDLE);
        rd_addr       = (r_state == ST_P0_RD) ? '0 : r_i[IW-1:0];
        div_req.start = 1'b0;
        div_req.steps = STEP_W'(TIME_W);
        div_rem_init  = '0;
        div_num_init  = {r_tm[TIME_W-1:0], FRAC_W'(0)};
        if (r_state == ST_SUM_RD && n_state == ST_DIV) begin
            div_req.start = 1'b1;
        end else if (r_state == ST_NEXT_USE && n_state == ST_FRAC) begin
            div_req.start = 1'b1;
            div_req.steps = STEP_W'(FRAC_W);
            div_rem_init  = rem_frac;
            div_num_init  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.kind == KIND_LOAD) &&
            (int'(i_in_data.point_index) < MAX_POINTS)) begin
            r_mem[IW'(i_in_data.point_index)] <= '{ticks: i_in_data.segment_ticks,
                                                  w: i_in_data.point_w,
                                                  z: i_in_data.point_z,
                                                  y: i_in_data.point_y,
                                                  x: i_in_data.point_x};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    kli_div #(
        .DW (TOTAL_W),
        .NW (NUM_W),
        .QW (32)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_rem_init (div_rem_init),
        .i_num_init (div_num_init),
        .i_divisor  ((r_state == ST_FRAC) ? TOTAL_W'(r_dprev) : r_total),
        .o_rsp      (div_rsp),
        .o_rem      (div_rem),
        .o_quo      (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) r_held[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                if (!r_inv) begin
                    for (int k = 0; k < 4; k++) r_held[k] <= r_res[k];
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_tm     <= TOTAL_W'(i_in_data.query_time - r_start_time);
                r_before <= i_in_data.query_time <= r_start_time;
                r_n      <= CW'(n32);
                r_nseg   <= CW'(n32 - 32'd1);
                r_i      <= '0;
                r_total  <= '0;
                r_walk   <= '0;
                r_inv    <= 1'b0;
                r_seg    <= '0;
                r_frac   <= '0;
            end
            ST_SUM_RD: begin
                if (r_n == '0) r_inv <= 1'b1;
                if (!(r_i < r_nseg)) r_i <= '0;
            end
            ST_SUM_USE: begin
                r_total <= r_total + TOTAL_W'(d_rd);
                r_i     <= r_i + CW'(1);
                if (d_rd == '0) r_inv <= 1'b1;
            end
            ST_P0_USE: begin
                for (int k = 0; k < 4; k++) r_res[k] <= coord_of(r_rd_data, 2'(k));
            end
            ST_DIV: begin
                if (div_rsp.done) r_tm <= tm_mod;
            end
            ST_WALK_USE: begin
                r_walk  <= r_walk + TOTAL_W'(d_rd);
                r_prev  <= r_rd_data;
                r_dprev <= d_rd;
                r_i     <= r_i + CW'(1);
            end
            ST_NEXT_USE: begin
                r_cur <= r_rd_data;
                r_j   <= '0;
                if (r_tm > r_walk) begin
                    r_seg <= 5'(r_n);
                    for (int k = 0; k < 4; k++) r_res[k] <= coord_of(r_rd_data, 2'(k));
                end else begin
                    r_seg <= 5'(r_i);
                    if (frac_full) r_frac <= 17'(1) << FRAC_W;
                end
            end
            ST_FRAC: begin
                if (div_rsp.done) r_frac <= 17'(div_quo[FRAC_W-1:0]);
            end
            ST_MUL: begin
                r_prod <= diff * frac_s;
            end
            ST_ADD: begin
                r_res[r_j] <= coord_a + 32'(r_prod >>> FRAC_W);
                r_j        <= r_j + 2'd1;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out.out_x    <= r_inv ? r_held[0] : r_res[0];
                    r_out.out_y    <= r_inv ? r_held[1] : r_res[1];
                    r_out.out_z    <= r_inv ? r_held[2] : r_res[2];
                    r_out.out_w    <= r_inv ? r_held[3] : r_res[3];
                    r_out.segment  <= r_seg;
                    r_out.fraction <= r_frac;
                    r_out.invalid  <= r_inv;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "keyframe_linear_interpolator_assert.svh"

    `KLI_ASSERT_NEXT(a_query_starts_sum, in_acc && (i_in_data.kind == KIND_QUERY), r_state == ST_SUM_RD)
    `KLI_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, (r_state == ST_DIV) || (r_state == ST_FRAC))
    `KLI_ASSERT_NOW(a_next_has_lower, r_state == ST_NEXT_USE, r_i != '0)
    `KLI_ASSERT_NEXT(a_done_publishes, (r_state == ST_DONE) && out_free, r_out_valid && (r_state == ST_IDLE))
    `KLI_ASSERT_NEXT(a_result_held, r_out_valid && i_out_stall, r_out_valid && $stable(r_out))

endmodule
`default_nettype wire

// ===== rtl/kli_div.sv =====
`default_nettype none
module kli_div #(
    parameter int DW = 36,
    parameter int NW = 48,
    parameter int QW = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  kli_pkg::t_div_req      i_req,
    input  wire  [DW-1:0]          i_rem_init,
    input  wire  [NW-1:0]          i_num_init,
    input  wire  [DW-1:0]          i_divisor,
    output kli_pkg::t_div_rsp      o_rsp,
    output logic [DW-1:0]          o_rem,
    output logic [QW-1:0]          o_quo
);
    import kli_pkg::*;

    logic [DW-1:0]     r_rem;
    logic [NW-1:0]     r_num;
    logic [QW-1:0]     r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DW:0]       shifted;
    logic              ge;

    assign shifted = {r_rem, r_num[NW-1]};
    assign ge      = shifted >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == STEP_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_rem_init;
            r_num <= i_num_init;
            r_quo <= '0;
            r_cnt <= i_req.steps;
        end else if (r_busy) begin
            r_rem <= ge ? DW'(shifted - {1'b0, i_divisor}) : shifted[DW-1:0];
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], ge};
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rem      = r_rem;
    assign o_quo      = r_quo;

endmodule
`default_nettype wire

// ===== tb/keyframe_linear_interpolator_checker.sv =====
`timescale 1ns / 1ps
module keyframe_linear_interpolator_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  kli_pkg::t_in_item   i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  kli_pkg::t_out_item  i_out_data,
    input  wire                 i_psel,
    input  wire                 i_penable,
    input  wire                 i_pwrite,
    input  wire                 i_pready,
    input  wire  [3:0]          i_paddr,
    input  wire  [31:0]         i_pwdata,
    output int                  o_fail_count,
    output int                  o_pending
);
    import kli_pkg::*;

    logic [31:0] start_reg;
    logic [1:0]  mode_reg;
    logic [4:0]  count_reg;
    logic        weight_reg;
    longint      key_coord[16][4];
    logic [31:0] key_ticks[16];
    longint      held_coord[4];
    t_out_item   expected_q[$];

    assign o_pending = expected_q.size();

    function automatic logic [63:0] ticks_of(input int k);
        if (weight_reg) begin
            if (key_coord[k][3] < 0) return 64'd0;
            return (key_coord[k][3] >>> 16) & 64'hFFFF_FFFF;
        end
        return {32'd0, key_ticks[k]};
    endfunction

    function automatic t_out_item pack_result(input longint c[4], input int seg,
                                              input logic [16:0] frac, input logic bad);
        t_out_item r;
        r.out_x    = c[0][31:0];
        r.out_y    = c[1][31:0];
        r.out_z    = c[2][31:0];
        r.out_w    = c[3][31:0];
        r.segment  = seg[4:0];
        r.fraction = frac;
        r.invalid  = bad;
        return r;
    endfunction

    task automatic predict_position(input logic [31:0] qt, output t_out_item r);
        int          n;
        int          k;
        logic        bad;
        logic [63:0] d[16];
        logic [63:0] total;
        logic [63:0] tm;
        logic [63:0] walk;
        logic [63:0] base;
        logic [63:0] period;
        logic [16:0] frac;
        longint      res[4];
        n = (count_reg > 16) ? 16 : count_reg;
        bad = (n == 0);
        total = 0;
        for (k = 0; k < n - 1; k++) begin
            d[k] = ticks_of(k);
            if (d[k] == 0) bad = 1;
            total += d[k];
        end
        if (bad) begin
            r = pack_result(held_coord, 0, 17'd0, 1'b1);
        end else if (qt <= start_reg || n == 1) begin
            for (k = 0; k < 4; k++) held_coord[k] = key_coord[0][k];
            r = pack_result(held_coord, 0, 17'd0, 1'b0);
        end else begin
            tm = qt - start_reg;
            if (mode_reg == MODE_LOOP) begin
                tm = tm % total;
            end else if (mode_reg == MODE_PINGPONG) begin
                period = tm / total;
                tm = tm % total;
                if (period[0]) tm = total - tm;
            end
            k = 0;
            walk = 0;
            while (k < n - 1 && tm >= walk) begin
                walk += d[k];
                k++;
            end
            if (tm > walk) begin
                for (int j = 0; j < 4; j++) res[j] = key_coord[n-1][j];
                r = pack_result(res, n, 17'd0, 1'b0);
            end else begin
                base = walk - d[k-1];
                if (tm - base >= d[k-1]) frac = 17'h10000;
                else frac = 17'(((tm - base) << 16) / d[k-1]);
                for (int j = 0; j < 4; j++)
                    res[j] = key_coord[k-1][j]
                           + (((key_coord[k][j] - key_coord[k-1][j]) * longint'(frac)) >>> 16);
                r = pack_result(res, k, frac, 1'b0);
            end
            for (int j = 0; j < 4; j++) held_coord[j] = res[j];
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            start_reg  <= 32'd0;
            mode_reg   <= MODE_ONCE;
            count_reg  <= 5'd5;
            weight_reg <= 1'b0;
            for (int j = 0; j < 4; j++) held_coord[j] = 0;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_START_TIME: start_reg  <= i_pwdata;
                    REG_PATH_MODE:  mode_reg   <= i_pwdata[1:0];
                    REG_POINT_CNT:  count_reg  <= i_pwdata[4:0];
                    REG_USE_WEIGHT: weight_reg <= i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = expected_q.pop_front();
                    if (exp_item.out_x !== i_out_data.out_x
                            || exp_item.out_y !== i_out_data.out_y
                            || exp_item.out_z !== i_out_data.out_z
                            || exp_item.out_w !== i_out_data.out_w
                            || exp_item.segment !== i_out_data.segment
                            || exp_item.fraction !== i_out_data.fraction
                            || exp_item.invalid !== i_out_data.invalid) begin
                        if (o_fail_count < 10)
                            $display("mismatch exp x=%h y=%h z=%h w=%h seg=%0d frac=%h inv=%b",
                                exp_item.out_x, exp_item.out_y, exp_item.out_z,
                                exp_item.out_w, exp_item.segment, exp_item.fraction,
                                exp_item.invalid, "\n         got x=%h y=%h z=%h w=%h seg=%0d frac=%h inv=%b",
                                i_out_data.out_x, i_out_data.out_y, i_out_data.out_z,
                                i_out_data.out_w, i_out_data.segment, i_out_data.fraction,
                                i_out_data.invalid);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.kind == KIND_LOAD) begin
                    key_ticks[i_in_data.point_index] = i_in_data.segment_ticks;
                    key_coord[i_in_data.point_index][0] = longint'(i_in_data.point_x);
                    key_coord[i_in_data.point_index][1] = longint'(i_in_data.point_y);
                    key_coord[i_in_data.point_index][2] = longint'(i_in_data.point_z);
                    key_coord[i_in_data.point_index][3] = longint'(i_in_data.point_w);
                end else begin
                    predict_position(i_in_data.query_time, exp_item);
                    expected_q.push_back(exp_item);
                end
            end
        end
    end

endmodule

// ===== tb/keyframe_linear_interpolator_tb.sv =====
`timescale 1ns / 1ps
module keyframe_linear_interpolator_tb;
    import kli_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          sent;
    logic [31:0] cur_start;
    logic        cur_weight;

    keyframe_linear_interpolator u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    keyframe_linear_interpolator_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stalls plus one long hold-off once traffic is flowing
    initial begin
        int  run;
        int  hold_cnt;
        bit  hold_done;
        bit  stalling;
        int  r;
        out_stall = 1'b0;
        run = 0;
        hold_cnt = 0;
        hold_done = 0;
        stalling = 0;
        forever begin
            @(posedge clk);
            if (!hold_done && sent >= 300) begin
                hold_done = 1;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_stall <= 1'b1;
            end else begin
                if (run == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 55) begin
                        stalling = 0;
                        run = $urandom_range(1, 30);
                    end else if (r < 93) begin
                        stalling = 1;
                        run = $urandom_range(1, 3);
                    end else begin
                        stalling = 1;
                        run = $urandom_range(20, 80);
                    end
                end
                run--;
                out_stall <= stalling;
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_beat(input t_in_item it);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic t_in_item random_beat();
        t_in_item     it;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        return it;
    endfunction

    function automatic logic [31:0] random_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 32'h8000_0000;
        if (r == 1) return 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    task automatic send_load(input int slot, input logic [31:0] ticks, input logic [31:0] w);
        t_in_item it;
        it = random_beat();
        it.kind          = KIND_LOAD;
        it.point_index   = slot[3:0];
        it.segment_ticks = ticks;
        it.point_x       = random_coord();
        it.point_y       = random_coord();
        it.point_z       = random_coord();
        it.point_w       = w;
        send_beat(it);
    endtask

    task automatic send_query(input logic [31:0] t);
        t_in_item it;
        it = random_beat();
        it.kind       = KIND_QUERY;
        it.query_time = t;
        send_beat(it);
    endtask

    task automatic random_load(input int slot);
        int          r;
        logic [31:0] ticks;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        ticks = (r < 3) ? 32'd0 : (r < 6) ? $urandom : $urandom_range(1, 300);
        r = $urandom_range(0, 99);
        if (r < 4) w = $urandom;
        else if (r < 6) w = {16'd0, 16'($urandom)};
        else w = {16'($urandom_range(1, 300)), 16'($urandom)};
        send_load(slot, ticks, w);
    endtask

    initial begin
        logic [31:0] starts[4];
        logic [4:0]  counts[7];
        int          r;
        logic [31:0] t;
        starts = '{32'd0, 32'd1000, 32'hFFFF_FFFF, 32'hFFFF_0000};
        counts = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd9};
        sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill every slot, then probe the path at reset settings
        for (int s = 0; s < 16; s++)
            send_load(s, (s == 0) ? 32'd1 : (s == 1) ? 32'hFFFF_FFFF : 32'd100,
                      {16'(s + 1), 16'h0000});
        send_query(32'd0);
        send_query(32'd1);
        send_query(32'd2);
        send_query(32'hFFFF_FFFF);
        send_query(32'h8000_0000);
        send_load(2, 32'd0, 32'h8000_0000);
        send_query(32'd50);
        send_load(2, 32'd100, 32'h7FFF_FFFF);
        send_query(32'd150);
        settle();

        for (int p = 0; p < 14; p++) begin
            cur_start  = (p % 5 == 4) ? $urandom : starts[p % 4];
            cur_weight = 1'((p / 4) % 2);
            reg_write(REG_START_TIME, cur_start);
            reg_write(REG_PATH_MODE, 32'(p % 4));
            reg_write(REG_POINT_CNT, 32'(counts[p % 7]));
            reg_write(REG_USE_WEIGHT, 32'(cur_weight));
            for (int s = 0; s < 16; s++)
                if ($urandom_range(0, 2) == 0) random_load(s);
            for (int k = 0; k < 70; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    random_load($urandom_range(0, 15));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 5) t = cur_start;
                    else if (r < 8) t = cur_start + 1;
                    else if (r < 12) t = $urandom;
                    else t = cur_start + $urandom_range(0, 12000);
                    send_query(t);
                end
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
